// ===== rtl/tmcw_pkg.sv =====
`timescale 1ns / 1ps
package tmcw_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // field and index widths
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CELL_W  = 16;
  localparam int ADDR_W  = $clog2(CELL_COUNT);
  localparam int IDX_W   = COL_W + ROW_W;
  localparam int CNT_W   = $clog2(CELL_COUNT + 1);
  localparam int SUM_W   = 10;

  // character codes
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;

  // operation codes
  localparam logic [2:0] FN_PUT_CHAR   = 3'd0;
  localparam logic [2:0] FN_PUT_HEX    = 3'd1;
  localparam logic [2:0] FN_CLEAR      = 3'd2;
  localparam logic [2:0] FN_PTR_ACT    = 3'd3;
  localparam logic [2:0] FN_PTR_MOVE   = 3'd4;
  localparam logic [2:0] FN_WRITE_CELL = 3'd5;
  localparam logic [2:0] FN_READ_CELL  = 3'd6;

  // sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CHAR,
    ST_CH_WR,
    ST_BLANK,
    ST_SW_RD,
    ST_SW_WR,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  // upper-case hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] d;
    if (n < 4'd10) begin
      d = 8'h30 + {4'h0, n};
    end else begin
      d = 8'h37 + {4'h0, n};
    end
    return d;
  endfunction

  // linear cell index of a screen position
  function automatic logic [ADDR_W-1:0] cell_idx(input logic [COL_W-1:0] col,
                                                 input logic [ROW_W-1:0] row);
    logic [IDX_W-1:0] t;
    t = IDX_W'(row) * IDX_W'(COLUMNS) + IDX_W'(col);
    return ADDR_W'(t);
  endfunction

  // exchange foreground and background nibbles of the attribute
  function automatic logic [CELL_W-1:0] swap_colours(input logic [CELL_W-1:0] c);
    return {c[11:8], c[15:12], c[7:0]};
  endfunction

endpackage

// ===== rtl/tmcw_in_if.sv =====
`timescale 1ns / 1ps
interface tmcw_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        func;
  logic [7:0]        byte_value;
  logic [10:0]       cell_address;
  logic [15:0]       cell_data;
  logic signed [7:0] move_x;
  logic signed [7:0] move_y;

  modport source (
    output valid, func, byte_value, cell_address, cell_data, move_x, move_y,
    input  ready
  );
  modport sink (
    input  valid, func, byte_value, cell_address, cell_data, move_x, move_y,
    output ready
  );
endinterface

// ===== rtl/tmcw_out_if.sv =====
`timescale 1ns / 1ps
interface tmcw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [6:0]  pointer_col;
  logic [4:0]  pointer_row;

  modport source (
    output valid, read_data, cursor_col, cursor_row, pointer_col, pointer_row,
    input  ready
  );
  modport sink (
    input  valid, read_data, cursor_col, cursor_row, pointer_col, pointer_row,
    output ready
  );
endinterface

// ===== rtl/tmcw_ram.sv =====
`timescale 1ns / 1ps
module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/text_mode_console_writer_unit.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake      payload
// in_ch     in   valid/ready    func, byte_value, cell_address, cell_data, move_x, move_y
// out_ch    out  valid/ready    read_data, cursor_col, cursor_row, pointer_col, pointer_row
//
// after reset a clearing pass writes zero to all 2000 cells, one per cycle,
// with in_ch.ready low
// put char, hex byte, pointer move and activate read-modify-write cells, raw read and write
// one cell; each cell read-modify-write goes through the single port pair of the cell store
// clear walks every cell, reading it and writing it back as a space; a scroll adds that walk
// one item at a time; in_ch is free while a result waits, the last step waits for out_ch
module text_mode_console_writer_unit (
  input  logic              clk,
  input  logic              rst_n,
  tmcw_in_if.sink           in_ch,
  tmcw_out_if.source        out_ch
);

  tmcw_pkg::state_t state_r, state_nxt;

  logic [tmcw_pkg::COL_W-1:0]  cursor_col_r, cursor_col_nxt;
  logic [tmcw_pkg::ROW_W-1:0]  cursor_row_r, cursor_row_nxt;
  logic [tmcw_pkg::COL_W-1:0]  pointer_col_r, pointer_col_nxt;
  logic [tmcw_pkg::ROW_W-1:0]  pointer_row_r, pointer_row_nxt;
  logic [tmcw_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        second_r, second_nxt;
  logic                        move_pend_r, move_pend_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic [7:0]                  char_r, char_nxt;
  logic [7:0]                  byte_r, byte_nxt;
  logic signed [7:0]           move_x_r, move_x_nxt;
  logic signed [7:0]           move_y_r, move_y_nxt;
  logic                        addr_ok_r, addr_ok_nxt;
  logic [tmcw_pkg::CELL_W-1:0] read_data_r, read_data_nxt;

  logic [tmcw_pkg::CELL_W-1:0] o_read_data_r, o_read_data_nxt;
  logic [tmcw_pkg::COL_W-1:0]  o_cursor_col_r, o_cursor_col_nxt;
  logic [tmcw_pkg::ROW_W-1:0]  o_cursor_row_r, o_cursor_row_nxt;
  logic [tmcw_pkg::COL_W-1:0]  o_pointer_col_r, o_pointer_col_nxt;
  logic [tmcw_pkg::ROW_W-1:0]  o_pointer_row_r, o_pointer_row_nxt;

  // cell store port signals
  logic                         ram_we;
  logic [tmcw_pkg::ADDR_W-1:0]  ram_wa;
  logic [tmcw_pkg::CELL_W-1:0]  ram_wd;
  logic                         ram_re;
  logic [tmcw_pkg::ADDR_W-1:0]  ram_ra;
  logic [tmcw_pkg::CELL_W-1:0]  ram_rd;

  // derived values
  logic [tmcw_pkg::ADDR_W-1:0]  cur_idx;
  logic [tmcw_pkg::ADDR_W-1:0]  ptr_idx;
  logic                         in_addr_ok;
  logic [tmcw_pkg::ADDR_W-1:0]  in_addr;
  logic                         is_newline;
  logic [tmcw_pkg::COL_W-1:0]   adv_col;
  logic [tmcw_pkg::ROW_W:0]     adv_row;
  logic                         adv_scroll;
  logic signed [tmcw_pkg::SUM_W-1:0] sum_x, sum_y;
  logic [tmcw_pkg::COL_W-1:0]   clamp_col;
  logic [tmcw_pkg::ROW_W-1:0]   clamp_row;

  tmcw_ram #(
    .WIDTH (tmcw_pkg::CELL_W),
    .DEPTH (tmcw_pkg::CELL_COUNT)
  ) u_cells (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .re      (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  // cell indexes and raw address check
  assign cur_idx    = tmcw_pkg::cell_idx(cursor_col_r, cursor_row_r);
  assign ptr_idx    = tmcw_pkg::cell_idx(pointer_col_r, pointer_row_r);
  assign in_addr_ok = {1'b0, in_ch.cell_address} < 12'(tmcw_pkg::CELL_COUNT);
  assign in_addr    = tmcw_pkg::ADDR_W'(in_ch.cell_address);

  // cursor advance after one character
  always_comb begin
    is_newline = (char_r == tmcw_pkg::NEWLINE_CODE);
    if (is_newline || cursor_col_r == tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS - 1)) begin
      adv_col = '0;
      adv_row = {1'b0, cursor_row_r} + 1'b1;
    end else begin
      adv_col = cursor_col_r + 1'b1;
      adv_row = {1'b0, cursor_row_r};
    end
    adv_scroll = (adv_row == (tmcw_pkg::ROW_W + 1)'(tmcw_pkg::ROWS));
  end

  // pointer offset with clamping into the screen
  always_comb begin
    sum_x = $signed(tmcw_pkg::SUM_W'(pointer_col_r)) + tmcw_pkg::SUM_W'(move_x_r);
    sum_y = $signed(tmcw_pkg::SUM_W'(pointer_row_r)) + tmcw_pkg::SUM_W'(move_y_r);
    if (sum_x < 0) begin
      clamp_col = '0;
    end else if (sum_x >= $signed(tmcw_pkg::SUM_W'(tmcw_pkg::COLUMNS))) begin
      clamp_col = tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS - 1);
    end else begin
      clamp_col = tmcw_pkg::COL_W'(sum_x);
    end
    if (sum_y < 0) begin
      clamp_row = '0;
    end else if (sum_y >= $signed(tmcw_pkg::SUM_W'(tmcw_pkg::ROWS))) begin
      clamp_row = tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1);
    end else begin
      clamp_row = tmcw_pkg::ROW_W'(sum_y);
    end
  end

  // sequencer: next state, store ports and register updates
  always_comb begin
    state_nxt         = state_r;
    cursor_col_nxt    = cursor_col_r;
    cursor_row_nxt    = cursor_row_r;
    pointer_col_nxt   = pointer_col_r;
    pointer_row_nxt   = pointer_row_r;
    cnt_nxt           = cnt_r;
    second_nxt        = second_r;
    move_pend_nxt     = move_pend_r;
    out_valid_nxt     = out_valid_r & ~out_ch.ready;
    char_nxt          = char_r;
    byte_nxt          = byte_r;
    move_x_nxt        = move_x_r;
    move_y_nxt        = move_y_r;
    addr_ok_nxt       = addr_ok_r;
    read_data_nxt     = read_data_r;
    o_read_data_nxt   = o_read_data_r;
    o_cursor_col_nxt  = o_cursor_col_r;
    o_cursor_row_nxt  = o_cursor_row_r;
    o_pointer_col_nxt = o_pointer_col_r;
    o_pointer_row_nxt = o_pointer_row_r;
    ram_we            = 1'b0;
    ram_wa            = '0;
    ram_wd            = '0;
    ram_re            = 1'b0;
    ram_ra            = '0;
    in_ch.ready       = 1'b0;

    unique case (state_r)
      tmcw_pkg::ST_INIT: begin
        // zero the store one cell a cycle
        ram_we = 1'b1;
        ram_wa = cnt_r[tmcw_pkg::ADDR_W-1:0];
        if (cnt_r == tmcw_pkg::CNT_W'(tmcw_pkg::CELL_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = tmcw_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      tmcw_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          byte_nxt      = in_ch.byte_value;
          move_x_nxt    = in_ch.move_x;
          move_y_nxt    = in_ch.move_y;
          read_data_nxt = '0;
          second_nxt    = 1'b0;
          move_pend_nxt = 1'b0;
          unique case (in_ch.func)
            tmcw_pkg::FN_PUT_CHAR: begin
              char_nxt  = in_ch.byte_value;
              state_nxt = tmcw_pkg::ST_CHAR;
            end
            tmcw_pkg::FN_PUT_HEX: begin
              char_nxt   = tmcw_pkg::hex_digit(in_ch.byte_value[7:4]);
              second_nxt = 1'b1;
              state_nxt  = tmcw_pkg::ST_CHAR;
            end
            tmcw_pkg::FN_CLEAR: begin
              cursor_col_nxt = '0;
              cursor_row_nxt = '0;
              cnt_nxt        = '0;
              state_nxt      = tmcw_pkg::ST_BLANK;
            end
            tmcw_pkg::FN_PTR_ACT: begin
              pointer_col_nxt = tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS / 2);
              pointer_row_nxt = tmcw_pkg::ROW_W'(tmcw_pkg::ROWS / 2);
              state_nxt       = tmcw_pkg::ST_SW_RD;
            end
            tmcw_pkg::FN_PTR_MOVE: begin
              move_pend_nxt = 1'b1;
              state_nxt     = tmcw_pkg::ST_SW_RD;
            end
            tmcw_pkg::FN_WRITE_CELL: begin
              ram_we    = in_addr_ok;
              ram_wa    = in_addr;
              ram_wd    = in_ch.cell_data;
              state_nxt = tmcw_pkg::ST_DONE;
            end
            tmcw_pkg::FN_READ_CELL: begin
              ram_re      = in_addr_ok;
              ram_ra      = in_addr;
              addr_ok_nxt = in_addr_ok;
              state_nxt   = tmcw_pkg::ST_RD_WAIT;
            end
            default: begin
              state_nxt = tmcw_pkg::ST_DONE;
            end
          endcase
        end
      end

      tmcw_pkg::ST_CHAR, tmcw_pkg::ST_CH_WR: begin
        if (state_r == tmcw_pkg::ST_CHAR && !is_newline) begin
          // fetch the cell under the cursor
          ram_re    = 1'b1;
          ram_ra    = cur_idx;
          state_nxt = tmcw_pkg::ST_CH_WR;
        end else begin
          // store the character with its attribute kept, then advance
          if (state_r == tmcw_pkg::ST_CH_WR) begin
            ram_we = 1'b1;
            ram_wa = cur_idx;
            ram_wd = {ram_rd[15:8], char_r};
          end
          if (adv_scroll) begin
            cursor_col_nxt = '0;
            cursor_row_nxt = '0;
            cnt_nxt        = '0;
            state_nxt      = tmcw_pkg::ST_BLANK;
          end else begin
            cursor_col_nxt = adv_col;
            cursor_row_nxt = tmcw_pkg::ROW_W'(adv_row);
            if (second_r) begin
              char_nxt   = tmcw_pkg::hex_digit(byte_r[3:0]);
              second_nxt = 1'b0;
              state_nxt  = tmcw_pkg::ST_CHAR;
            end else begin
              state_nxt = tmcw_pkg::ST_DONE;
            end
          end
        end
      end

      tmcw_pkg::ST_BLANK: begin
        // read cell n while writing back cell n-1 as a space
        if (cnt_r < tmcw_pkg::CNT_W'(tmcw_pkg::CELL_COUNT)) begin
          ram_re = 1'b1;
          ram_ra = cnt_r[tmcw_pkg::ADDR_W-1:0];
        end
        if (cnt_r != '0) begin
          ram_we = 1'b1;
          ram_wa = tmcw_pkg::ADDR_W'(cnt_r - 1'b1);
          ram_wd = {ram_rd[15:8], tmcw_pkg::SPACE_CODE};
        end
        if (cnt_r == tmcw_pkg::CNT_W'(tmcw_pkg::CELL_COUNT)) begin
          cnt_nxt = '0;
          if (second_r) begin
            char_nxt   = tmcw_pkg::hex_digit(byte_r[3:0]);
            second_nxt = 1'b0;
            state_nxt  = tmcw_pkg::ST_CHAR;
          end else begin
            state_nxt = tmcw_pkg::ST_DONE;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      tmcw_pkg::ST_SW_RD: begin
        ram_re    = 1'b1;
        ram_ra    = ptr_idx;
        state_nxt = tmcw_pkg::ST_SW_WR;
      end

      tmcw_pkg::ST_SW_WR: begin
        ram_we = 1'b1;
        ram_wa = ptr_idx;
        ram_wd = tmcw_pkg::swap_colours(ram_rd);
        if (move_pend_r) begin
          // old cell restored, now mark the new one
          pointer_col_nxt = clamp_col;
          pointer_row_nxt = clamp_row;
          move_pend_nxt   = 1'b0;
          state_nxt       = tmcw_pkg::ST_SW_RD;
        end else begin
          state_nxt = tmcw_pkg::ST_DONE;
        end
      end

      tmcw_pkg::ST_RD_WAIT: begin
        read_data_nxt = addr_ok_r ? ram_rd : '0;
        state_nxt     = tmcw_pkg::ST_DONE;
      end

      tmcw_pkg::ST_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt     = 1'b1;
          o_read_data_nxt   = read_data_r;
          o_cursor_col_nxt  = cursor_col_r;
          o_cursor_row_nxt  = cursor_row_r;
          o_pointer_col_nxt = pointer_col_r;
          o_pointer_row_nxt = pointer_row_r;
          state_nxt         = tmcw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tmcw_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tmcw_pkg::ST_INIT;
      cursor_col_r  <= '0;
      cursor_row_r  <= '0;
      pointer_col_r <= '0;
      pointer_row_r <= '0;
      cnt_r         <= '0;
      second_r      <= 1'b0;
      move_pend_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cursor_col_r  <= cursor_col_nxt;
      cursor_row_r  <= cursor_row_nxt;
      pointer_col_r <= pointer_col_nxt;
      pointer_row_r <= pointer_row_nxt;
      cnt_r         <= cnt_nxt;
      second_r      <= second_nxt;
      move_pend_r   <= move_pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    char_r          <= char_nxt;
    byte_r          <= byte_nxt;
    move_x_r        <= move_x_nxt;
    move_y_r        <= move_y_nxt;
    addr_ok_r       <= addr_ok_nxt;
    read_data_r     <= read_data_nxt;
    o_read_data_r   <= o_read_data_nxt;
    o_cursor_col_r  <= o_cursor_col_nxt;
    o_cursor_row_r  <= o_cursor_row_nxt;
    o_pointer_col_r <= o_pointer_col_nxt;
    o_pointer_row_r <= o_pointer_row_nxt;
  end

  // result beat
  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = o_read_data_r;
  assign out_ch.cursor_col  = o_cursor_col_r;
  assign out_ch.cursor_row  = o_cursor_row_r;
  assign out_ch.pointer_col = o_pointer_col_r;
  assign out_ch.pointer_row = o_pointer_row_r;

  // cursor never leaves the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_col_r < tmcw_pkg::COLUMNS) && (cursor_row_r < tmcw_pkg::ROWS))
    else $error("cursor outside screen");

  // pointer never leaves the screen
  a_pointer_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pointer_col_r < tmcw_pkg::COLUMNS) && (pointer_row_r < tmcw_pkg::ROWS))
    else $error("pointer outside screen");

  // a result beat is raised only by the final step of an item
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tmcw_pkg::ST_DONE))
    else $error("result raised outside done step");

  // in idle the store is written only by a raw write beat
  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tmcw_pkg::ST_IDLE && ram_we) |->
      (in_ch.valid && in_ch.func == tmcw_pkg::FN_WRITE_CELL))
    else $error("unexpected cell write in idle");

endmodule
